// File: rtl/ilc_pkg.sv
// Shared types and constants for the settings-file line classifier.
package ilc_pkg;

    localparam int FIELD_W = 11;

    typedef logic [FIELD_W-1:0] field_t;

    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_SECT  = 3'd1;
    localparam logic [2:0] PH_KEY   = 3'd2;
    localparam logic [2:0] PH_VLEAD = 3'd3;
    localparam logic [2:0] PH_VAL   = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;

    localparam logic [1:0] KIND_SECTION = 2'd0;
    localparam logic [1:0] KIND_KV      = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef struct packed {
        field_t     value_stop;
        field_t     value_first;
        field_t     name_stop;
        field_t     name_first;
        logic [1:0] line_kind;
    } result_t;

endpackage

// File: rtl/ini_line_classifier.sv
// Top level of the settings-file line classifier: phase machine and result buffer.
//
// Accepts one character beat per cycle with no gaps while s_tready is high, and the
// result of a line is registered when its tlast beat is accepted. The phase machine
// and position counters update in the cycle a beat is accepted; a two-entry
// output buffer keeps the input side taking beats while a result waits, and
// s_tready drops only when both entries are full. Positions count from zero,
// saturate at LINE_SIZE-1 and are reported in 11 bits.
module ini_line_classifier #(
    parameter int LINE_SIZE = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: char_code[7:0]; tlast: line_end
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    // tdata: name_first[10:0], name_stop[21:11], value_first[32:22],
    //        value_stop[43:33], zero fill[47:44]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // tuser: line_kind[1:0]
    output logic [1:0]  m_tuser
);
    import ilc_pkg::*;

    localparam int POS_W = $clog2(LINE_SIZE);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(LINE_SIZE - 1);

    logic [2:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] solid_reg, solid_next;
    logic [POS_W-1:0] eq_reg, eq_next;
    logic [POS_W-1:0] vbeg_reg, vbeg_next;
    logic [POS_W-1:0] vend_reg, vend_next;
    logic [1:0]       kind_reg, kind_next;

    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] solid_inc;
    logic             is_blank;
    logic             is_term;
    logic             accept;
    logic             push;
    logic             pop;
    result_t          res;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;

    assign accept = s_tvalid && s_tready;
    assign push   = accept && s_tlast;
    assign pop    = main_valid_reg && m_tready;

    assign pos_inc   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
    assign is_blank  = (s_tdata == CH_SPACE) || ((s_tdata >= CH_TAB) && (s_tdata <= CH_CR));
    assign is_term   = (s_tdata == CH_NUL) || (s_tdata == CH_CR) || (s_tdata == CH_LF);

    always_comb begin
        phase_next = phase_reg;
        start_next = start_reg;
        solid_next = solid_reg;
        eq_next    = eq_reg;
        vbeg_next  = vbeg_reg;
        vend_next  = vend_reg;
        kind_next  = kind_reg;
        pos_next   = pos_inc;
        case (phase_reg)
            PH_LEAD: begin
                if ((s_tdata == CH_NUL) || (s_tdata == CH_SEMI)) begin
                    phase_next = PH_DONE;
                end else if (is_blank) begin
                    phase_next = PH_LEAD;
                end else if (s_tdata == CH_LBRACK) begin
                    start_next = pos_inc;
                    phase_next = PH_SECT;
                end else begin
                    start_next = pos_reg;
                    solid_next = pos_reg;
                    phase_next = PH_KEY;
                end
            end
            PH_SECT: begin
                if (is_term) begin
                    phase_next = PH_DONE;
                end else if (s_tdata == CH_RBRACK) begin
                    eq_next    = pos_reg;
                    kind_next  = KIND_SECTION;
                    phase_next = PH_DONE;
                end
            end
            PH_KEY: begin
                if (is_term) begin
                    phase_next = PH_DONE;
                end else if (s_tdata == CH_EQUALS) begin
                    eq_next    = pos_reg;
                    vbeg_next  = pos_inc;
                    vend_next  = pos_inc;
                    kind_next  = KIND_KV;
                    phase_next = PH_VLEAD;
                end else if (!is_blank) begin
                    solid_next = pos_reg;
                end
            end
            PH_VLEAD: begin
                if (is_term) begin
                    phase_next = PH_DONE;
                end else if (!is_blank) begin
                    vbeg_next  = pos_reg;
                    vend_next  = pos_inc;
                    phase_next = PH_VAL;
                end
            end
            PH_VAL: begin
                if (is_term) begin
                    phase_next = PH_DONE;
                end else if (!is_blank) begin
                    vend_next = pos_inc;
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign solid_inc = (solid_next == POS_MAX) ? solid_next : solid_next + POS_W'(1);

    logic [31:0] start_w, eq_w, solid_w, vbeg_w, vend_w;
    assign start_w = 32'(start_next);
    assign eq_w    = 32'(eq_next);
    assign solid_w = 32'(solid_inc);
    assign vbeg_w  = 32'(vbeg_next);
    assign vend_w  = 32'(vend_next);

    always_comb begin
        res.line_kind   = kind_next;
        res.name_first  = '0;
        res.name_stop   = '0;
        res.value_first = '0;
        res.value_stop  = '0;
        case (kind_next)
            KIND_SECTION: begin
                res.name_first = start_w[FIELD_W-1:0];
                res.name_stop  = eq_w[FIELD_W-1:0];
            end
            KIND_KV: begin
                res.name_first  = start_w[FIELD_W-1:0];
                res.name_stop   = solid_w[FIELD_W-1:0];
                res.value_first = vbeg_w[FIELD_W-1:0];
                res.value_stop  = vend_w[FIELD_W-1:0];
            end
            default: begin
                res.name_first = '0;
            end
        endcase
    end

    // advance the line state; return to reset after the last beat of a line
    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            phase_reg <= PH_LEAD;
            pos_reg   <= '0;
            start_reg <= '0;
            solid_reg <= '0;
            eq_reg    <= '0;
            vbeg_reg  <= '0;
            vend_reg  <= '0;
            kind_reg  <= KIND_EMPTY;
        end else if (accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            solid_reg <= solid_next;
            eq_reg    <= eq_next;
            vbeg_reg  <= vbeg_next;
            vend_reg  <= vend_next;
            kind_reg  <= kind_next;
        end
    end

    assign s_tready = !skid_valid_reg;

    // hold a result in the skid entry while the main entry is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tuser  = main_reg.line_kind;
    assign m_tdata  = {4'b0000, main_reg.value_stop, main_reg.value_first,
                       main_reg.name_stop, main_reg.name_first};

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the settings-file line classifier.
module testbench;

    import ilc_pkg::*;

    localparam int          LINE_SIZE      = 2048;
    localparam field_t      POS_MAX        = field_t'(LINE_SIZE - 1);
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          RANDOM_BEATS   = 500;
    localparam int          PRINT_CAP      = 100;
    localparam logic [7:0]  CH_VT          = 8'h0B;
    localparam logic [7:0]  CH_FF          = 8'h0C;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // char_code[7:0]
    logic        s_tlast = 1'b0;    // line_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // name_first, name_stop, value_first, value_stop, zero fill
    logic [1:0]  m_tuser;           // line_kind

    // Predicted line state
    logic [2:0]  ph;
    field_t      pos;
    field_t      first_pos;
    field_t      key_solid;
    field_t      mark_pos;
    field_t      val_lo;
    field_t      val_hi;
    logic [1:0]  kind_seen;

    result_t     line_results_due[$];
    logic [7:0]  line_buf[$];
    int          mismatch_count = 0;
    int          beat_count = 0;
    int          idle_cycles = 0;
    int unsigned hold_off = 0;
    int unsigned stall_left = 0;
    bit          steady = 1'b0;

    ini_line_classifier #(.LINE_SIZE(LINE_SIZE)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_term(input logic [7:0] c);
        return c == CH_NUL || c == CH_CR || c == CH_LF;
    endfunction

    function automatic field_t step_pos(input field_t p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_line();
        ph        = PH_LEAD;
        pos       = '0;
        first_pos = '0;
        key_solid = '0;
        mark_pos  = '0;
        val_lo    = '0;
        val_hi    = '0;
        kind_seen = KIND_EMPTY;
    endtask

    task automatic classify_char(input logic [7:0] c, input logic is_end);
        result_t r;
        case (ph)
            PH_LEAD: begin
                if (c == CH_NUL || c == CH_SEMI) begin
                    ph = PH_DONE;
                end else if (!is_blank(c)) begin
                    if (c == CH_LBRACK) begin
                        first_pos = step_pos(pos);
                        ph = PH_SECT;
                    end else begin
                        first_pos = pos;
                        key_solid = pos;
                        ph = PH_KEY;
                    end
                end
            end
            PH_SECT: begin
                if (is_term(c)) begin
                    ph = PH_DONE;
                end else if (c == CH_RBRACK) begin
                    mark_pos = pos;
                    kind_seen = KIND_SECTION;
                    ph = PH_DONE;
                end
            end
            PH_KEY: begin
                if (is_term(c)) begin
                    ph = PH_DONE;
                end else if (c == CH_EQUALS) begin
                    mark_pos = pos;
                    val_lo = step_pos(pos);
                    val_hi = val_lo;
                    kind_seen = KIND_KV;
                    ph = PH_VLEAD;
                end else if (!is_blank(c)) begin
                    key_solid = pos;
                end
            end
            PH_VLEAD: begin
                if (is_term(c)) begin
                    ph = PH_DONE;
                end else if (!is_blank(c)) begin
                    val_lo = pos;
                    val_hi = step_pos(pos);
                    ph = PH_VAL;
                end
            end
            PH_VAL: begin
                if (is_term(c)) begin
                    ph = PH_DONE;
                end else if (!is_blank(c)) begin
                    val_hi = step_pos(pos);
                end
            end
            default: ;
        endcase
        pos = step_pos(pos);
        if (is_end) begin
            r = '0;
            r.line_kind = kind_seen;
            if (kind_seen == KIND_SECTION) begin
                r.name_first = first_pos;
                r.name_stop  = mark_pos;
            end else if (kind_seen == KIND_KV) begin
                r.name_first  = first_pos;
                r.name_stop   = step_pos(key_solid);
                r.value_first = val_lo;
                r.value_stop  = val_hi;
            end
            line_results_due.push_back(r);
            clear_line();
        end
    endtask

    task automatic send_beat(input logic [7:0] c, input logic is_end);
        int unsigned n;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        classify_char(c, is_end);
        beat_count++;
        n = gap_len();
        if (n != 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_beat(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        put_str(s);
        send_line();
    endtask

    task automatic put_repeat(input logic [7:0] c, input int n);
        repeat (n) line_buf.push_back(c);
    endtask

    function automatic logic [7:0] blank_char(input bit lead);
        logic [7:0] pick[6];
        pick = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR, CH_LF};
        return pick[$urandom_range(0, lead ? 5 : 3)];
    endfunction

    function automatic logic [7:0] word_char(input bit key);
        logic [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7E));
        if (key && (c == CH_EQUALS || c == CH_SEMI || c == CH_LBRACK || c == CH_RBRACK))
            c = 8'h6B;
        if ($urandom_range(0, 15) == 0)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic put_blanks(input int n, input bit lead);
        repeat (n) line_buf.push_back(blank_char(lead));
    endtask

    task automatic put_word(input int n, input bit key);
        repeat (n) line_buf.push_back(word_char(key));
    endtask

    task automatic make_random_line();
        int form;
        logic [7:0] stops[3];
        stops = '{CH_CR, CH_LF, CH_NUL};
        form = $urandom_range(0, 9);
        put_blanks($urandom_range(0, 3), 1'b1);
        case (form)
            0, 1, 2, 3, 8: begin
                put_word($urandom_range(1, 6), 1'b1);
                put_blanks($urandom_range(0, 2), 1'b0);
                line_buf.push_back(CH_EQUALS);
                put_blanks($urandom_range(0, 2), 1'b0);
                put_word($urandom_range(0, 6), 1'b0);
                put_blanks($urandom_range(0, 2), 1'b0);
                if (form == 8) begin
                    line_buf.push_back(stops[$urandom_range(0, 2)]);
                    put_word($urandom_range(0, 4), 1'b0);
                end
            end
            4, 5: begin
                line_buf.push_back(CH_LBRACK);
                put_word($urandom_range(0, 6), 1'b1);
                if ($urandom_range(0, 7) != 0)
                    line_buf.push_back(CH_RBRACK);
                put_word($urandom_range(0, 3), 1'b0);
            end
            6: begin
                line_buf.push_back(CH_SEMI);
                put_word($urandom_range(0, 8), 1'b0);
            end
            7: begin
                repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                if ($urandom_range(0, 1) == 0)
                    line_buf.push_back(CH_EQUALS);
                put_word($urandom_range(1, 6), 1'b1);
                put_blanks($urandom_range(0, 2), 1'b0);
            end
        endcase
        if (line_buf.size() == 0)
            line_buf.push_back(CH_SPACE);
    endtask

    task automatic test_directed();
        send_text("[ab]");
        send_text("[]");
        send_text(" \t key1 \t= value x \t");
        send_text("k=");
        send_text("k=  \t");
        send_text(";comment = x");
        send_text("  ;");
        line_buf.push_back(CH_NUL);
        send_line();
        put_str("  ");
        line_buf.push_back(CH_NUL);
        send_text("k=v");
        send_text("[abc");
        send_text("key only");
        send_text("=a=b");
        put_str("\r\n\t");
        line_buf.push_back(CH_VT);
        line_buf.push_back(CH_FF);
        send_text(" k=v");
        put_str("k=v");
        line_buf.push_back(CH_CR);
        send_text("=junk]");
        put_str("k = v w");
        line_buf.push_back(CH_LF);
        send_text("more");
        put_str("[a");
        line_buf.push_back(CH_LF);
        send_text("]");
        put_str("key");
        line_buf.push_back(CH_NUL);
        send_text("=v");
        send_text("a");
        send_text("[");
        send_text("]");
        send_text("    ");
        put_str("k=");
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h80);
        line_buf.push_back(8'h7F);
        send_line();
        line_buf.push_back(8'hFF);
        send_text("=1");
    endtask

    task automatic test_long_lines();
        put_str("k=");
        put_repeat(8'h78, LINE_SIZE + 60);
        send_line();
        line_buf.push_back(CH_LBRACK);
        put_repeat(8'h6E, LINE_SIZE + 40);
        send_text("]");
        put_str("k");
        put_repeat(CH_SPACE, LINE_SIZE + 30);
        send_text("= v");
    endtask

    task automatic test_backpressure();
        steady = 1'b1;
        hold_off = 300;
        repeat (30) send_text("a=b");
        steady = 1'b0;
    endtask

    task automatic test_steady_stream();
        int start;
        start = beat_count;
        steady = 1'b1;
        while (beat_count - start < 80) begin
            make_random_line();
            send_line();
        end
        steady = 1'b0;
    endtask

    task automatic test_random();
        int start;
        start = beat_count;
        while (beat_count - start < RANDOM_BEATS) begin
            make_random_line();
            send_line();
        end
    endtask

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off != 0) begin
                m_tready <= 1'b0;
                hold_off--;
            end else if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (line_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= PRINT_CAP)
                    $display("%0t: unexpected result, expected none, got kind %0d tdata %h",
                             $time, m_tuser, m_tdata);
            end else begin
                want = line_results_due.pop_front();
                check_field("line_kind", int'(want.line_kind), int'(m_tuser));
                check_field("name_first", int'(want.name_first), int'(m_tdata[10:0]));
                check_field("name_stop", int'(want.name_stop), int'(m_tdata[21:11]));
                check_field("value_first", int'(want.value_first), int'(m_tdata[32:22]));
                check_field("value_stop", int'(want.value_stop), int'(m_tdata[43:33]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        clear_line();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_long_lines();
        test_backpressure();
        test_steady_stream();
        test_random();
        s_tvalid <= 1'b0;
        while (line_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ilc_pkg.sv
rtl/ini_line_classifier.sv
tb/sv/testbench.sv
